### src/window_avg_max_min_reducer_unit_macros.svh
// Assertion macros for the window reducer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WINDOW_AVG_MAX_MIN_REDUCER_UNIT_MACROS_SVH
`define WINDOW_AVG_MAX_MIN_REDUCER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property with the synchronous reset as the disable condition.
`define WAMR_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("window reducer assertion failed");
// Checked property that must hold during reset as well.
`define WAMR_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("window reducer assertion failed");
`else
`define WAMR_ASSERT(lbl, clk_sig, rst_sig, prop)
`define WAMR_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif
`endif

### src/wamr_pkg.sv
// Shared types, constants and the code-to-voltage scaling for the window reducer.
// No dependencies.
`default_nettype none
package wamr_pkg;

  localparam int unsigned WINDOW = 10;

  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VOLT_W  = 6;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned MODE_W  = 2;

  localparam int unsigned SCALE_NUM  = 33;
  localparam int unsigned SCALE_DEN  = 1023;
  localparam int unsigned SCALE_SH   = 10;
  localparam int unsigned PROD_W     = 16;

  localparam logic [VOLT_W-1:0] MIN_RESET  = VOLT_W'(SCALE_NUM);
  localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'(WINDOW - 1);

  // Reciprocal for the division of the window sum by WINDOW.
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int unsigned AVG_PROD_W = SUM_W + RECIP_W;

  localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [VOLT_W-1:0] volts;
  } sample_t;

  // (code * 33) / 1023. The denominator is one less than 2**10, so the
  // remainder after a shift is the low bits plus the quotient, and it stays
  // below twice the denominator: one compare corrects the quotient.
  function automatic logic [VOLT_W-1:0] scale_code(input logic [CODE_W-1:0] code);
    logic [PROD_W-1:0]     prod;
    logic [VOLT_W-1:0]     q0;
    logic [SCALE_SH:0]     rem;
    prod = PROD_W'(code) * PROD_W'(SCALE_NUM);
    q0   = prod[SCALE_SH +: VOLT_W];
    rem  = {1'b0, prod[SCALE_SH-1:0]} + (SCALE_SH + 1)'(q0);
    if (rem >= (SCALE_SH + 1)'(SCALE_DEN)) begin
      scale_code = q0 + VOLT_W'(1);
    end else begin
      scale_code = q0;
    end
  endfunction

endpackage
`default_nettype wire

### src/wamr_scale.sv
// Input stage: registers each accepted item as a scaled voltage.
// Depends on wamr_pkg.
`default_nettype none
module wamr_scale
  import wamr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [CODE_W-1:0] sample_code,
  output      sample_t           stage,
  input  wire logic              stage_stall
);

  logic              s1_valid;
  logic [VOLT_W-1:0] s1_volts;

  // The stage only holds when it carries an item that the next stage refuses.
  assign in_stall = s1_valid && stage_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_volts <= scale_code(sample_code);
    end
  end

  assign stage.valid = s1_valid;
  assign stage.volts = s1_volts;

endmodule
`default_nettype wire

### src/wamr_accum.sv
// Window accumulators, mode register and result register.
// Depends on wamr_pkg and the assertion macros header.
`include "window_avg_max_min_reducer_unit_macros.svh"
`default_nettype none
module wamr_accum
  import wamr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [MODE_W-1:0] cfg_wr_data,
  input  wire sample_t           stage,
  output      logic              stage_stall,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [VOLT_W-1:0] window_value
);

  logic [MODE_W-1:0]     reduce_mode;
  logic [SUM_W-1:0]      running_sum;
  logic [CNT_W-1:0]      sample_count;
  logic [VOLT_W-1:0]     running_max;
  logic [VOLT_W-1:0]     running_min;

  logic [SUM_W-1:0]      sum_next;
  logic [VOLT_W-1:0]     max_next;
  logic [VOLT_W-1:0]     min_next;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [VOLT_W-1:0]     result_next;
  logic                  closing;
  logic                  consume;

  assign closing     = (sample_count == LAST_COUNT);
  // Only the closing item needs the result register, so only it can be held.
  assign stage_stall = closing && out_valid && out_stall;
  assign consume     = stage.valid && !stage_stall;

  assign sum_next = running_sum + SUM_W'(stage.volts);
  assign max_next = (stage.volts > running_max) ? stage.volts : running_max;
  assign min_next = (stage.volts < running_min) ? stage.volts : running_min;
  assign avg_prod = AVG_PROD_W'(sum_next) * AVG_PROD_W'(AVG_RECIP);

  always_comb begin
    case (reduce_mode)
      MODE_AVG: result_next = avg_prod[DIV_SHIFT +: VOLT_W];
      MODE_MAX: result_next = max_next;
      MODE_MIN: result_next = min_next;
      default:  result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_MAX;
    end else if (cfg_wr_en) begin
      reduce_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      sample_count <= '0;
      running_max  <= '0;
      running_min  <= MIN_RESET;
    end else if (consume) begin
      if (closing) begin
        running_sum  <= '0;
        sample_count <= '0;
        running_max  <= '0;
        running_min  <= MIN_RESET;
      end else begin
        running_sum  <= sum_next;
        sample_count <= sample_count + CNT_W'(1);
        running_max  <= max_next;
        running_min  <= min_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && closing) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && closing) begin
      window_value <= result_next;
    end
  end

  `WAMR_ASSERT(a_count_in_window, clk, rst, sample_count <= LAST_COUNT)
  `WAMR_ASSERT(a_stall_needs_result, clk, rst, stage_stall |-> (out_valid && closing))
  `WAMR_ASSERT(a_close_clears, clk, rst, (consume && closing) |=> (sample_count == '0 && running_min == MIN_RESET && out_valid))
  `WAMR_ASSERT(a_count_steps, clk, rst, (consume && !closing) |=> (sample_count == $past(sample_count) + CNT_W'(1)))

endmodule
`default_nettype wire

### src/window_avg_max_min_reducer_unit.sv
// Window reducer for 10-bit ADC codes: average, maximum or minimum per window.
// Top level; depends on wamr_pkg, wamr_scale and wamr_accum.
//
// Input channel: sample_code with in_valid; the block raises in_stall to hold
// an item back. Output channel: window_value with out_valid; the receiver
// raises out_stall to hold a result. An item moves at a clock edge where its
// valid is high and its stall is low.
// Each item is scaled to tenths of a volt and folded into the running sum,
// maximum and minimum; every WINDOW-th item closes the window and the result
// register takes its result. One item is taken per cycle unless in_stall.
// cfg_wr_en with cfg_wr_data sets reduce_mode (0 average, 1 maximum,
// 2 minimum, 3 gives zero); write it only while the block is idle.
// Synchronous reset clears both stages, empties the window and sets the
// mode to maximum. While out_stall holds a result, items keep flowing until
// the next window-closing item reaches the input register; that item then
// waits there and in_stall stays high until the held result is taken.
`default_nettype none
module window_avg_max_min_reducer_unit
  import wamr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [MODE_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [CODE_W-1:0] sample_code,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [VOLT_W-1:0] window_value
);

  sample_t stage;
  logic    stage_stall;

  wamr_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_code (sample_code),
    .stage       (stage),
    .stage_stall (stage_stall)
  );

  wamr_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .stage        (stage),
    .stage_stall  (stage_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_value (window_value)
  );

endmodule
`default_nettype wire
